/* src/midpoint_line_rasterizer_assert.svh */
// ----------------------------------------------------------------------------
// Midpoint line rasterizer assertion macros
// Clocked implication checks used by the rasterizer walker. Each macro
// expects signals named clock and reset in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define MLR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlr: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define MLR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlr: next-cycle check failed");

`endif

/* src/mlr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Widths, the segment descriptor passed from setup to walker, and the
// walker state encoding.
// ----------------------------------------------------------------------------
package mlr_pkg;

   // Grid coordinate width
   localparam int COORD_BITS = 6;
   // Decision variable spans about +/- 4 * grid size
   localparam int D_BITS     = COORD_BITS + 3;
   // Doubled increments
   localparam int INC_BITS   = COORD_BITS + 1;

   // Segment queue depth
   localparam int FIFO_DEPTH    = 2;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // Classified segment, ready to walk
   typedef struct packed {
      logic [COORD_BITS-1:0]    sx;
      logic [COORD_BITS-1:0]    sy;
      logic [COORD_BITS-1:0]    span;
      logic                     xmajor;
      logic                     ydown;
      logic signed [D_BITS-1:0] d_init;
      logic [INC_BITS-1:0]      inc_diag;
      logic [INC_BITS-1:0]      inc_straight;
   } seg_type;

   // Walker sequencer
   typedef enum logic {
      WALK_IDLE,
      WALK_RUN
   } walk_state_type;

endpackage

/* src/mlr_setup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasterizer setup
// Orders the endpoints, picks the major axis and direction, and computes
// the initial decision variable and the doubled increments of a segment.
// ----------------------------------------------------------------------------
module mlr_setup import mlr_pkg::*; (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic                  push,
   input  logic                  push_ready,
   output seg_type               seg
);

   logic                  swapped;
   logic                  ydown;
   logic                  xmajor;
   logic [COORD_BITS-1:0] sx, sy, fx, fy;
   logic [COORD_BITS-1:0] adx, ady;
   logic [COORD_BITS-1:0] major, minor;

   // Accept a beat whenever the queue has room
   assign req_ready = push_ready;
   assign push      = req_valid && push_ready;

   // Order endpoints so x never decreases, then classify
   always_comb begin
      swapped = req_x_end < req_x_start;
      sx      = swapped ? req_x_end   : req_x_start;
      sy      = swapped ? req_y_end   : req_y_start;
      fx      = swapped ? req_x_start : req_x_end;
      fy      = swapped ? req_y_start : req_y_end;
      adx     = fx - sx;
      ydown   = fy < sy;
      ady     = ydown ? (sy - fy) : (fy - sy);
      // Upward unswapped lines break a tie toward x, all others toward y
      if (!swapped && !ydown) begin
         xmajor = ady <= adx;
      end else begin
         xmajor = adx > ady;
      end
      major = xmajor ? adx : ady;
      minor = xmajor ? ady : adx;

      seg.sx           = sx;
      seg.sy           = sy;
      seg.span         = major;
      seg.xmajor       = xmajor;
      seg.ydown        = ydown;
      seg.d_init       = $signed({3'b000, major}) - $signed({2'b00, minor, 1'b0});
      seg.inc_diag     = {major - minor, 1'b0};
      seg.inc_straight = {minor, 1'b0};
   end

endmodule

/* src/mlr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasterizer segment queue
// Short FIFO of classified segments between setup and walker.
// ----------------------------------------------------------------------------
module mlr_fifo import mlr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    push_ready,
   input  seg_type push_seg,
   input  logic    pop,
   output logic    pop_valid,
   output seg_type pop_seg
);

   seg_type                  entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = count_ff != FIFO_CNT_BITS'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_seg    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                     : wr_ptr_ff + FIFO_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                     : rd_ptr_ff + FIFO_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed segment
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_seg;
      end
   end

endmodule

/* src/mlr_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasterizer walker
// Steps one segment pixel by pixel under the midpoint decision variable
// and presents each pixel in an output register.
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_assert.svh"

module mlr_walk import mlr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  seg_valid,
   input  seg_type               seg,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_last_pixel
);

   walk_state_type           state_ff, state_in;
   logic [COORD_BITS-1:0]    x_ff, x_in;
   logic [COORD_BITS-1:0]    y_ff, y_in;
   logic signed [D_BITS-1:0] d_ff, d_in;
   logic [COORD_BITS-1:0]    left_ff, left_in;
   logic                     xmajor_ff, xmajor_in;
   logic                     ydown_ff, ydown_in;
   logic [INC_BITS-1:0]      inc_diag_ff, inc_diag_in;
   logic [INC_BITS-1:0]      inc_straight_ff, inc_straight_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]    pix_x_ff, pix_x_in;
   logic [COORD_BITS-1:0]    pix_y_ff, pix_y_in;
   logic                     last_ff, last_in;
   logic                     out_free;
   logic                     emit;
   logic                     last_now;
   logic                     take_diag;
   logic [COORD_BITS-1:0]    y_step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_now  = left_ff == '0;
   assign take_diag = d_ff[D_BITS-1] || (d_ff == '0);
   assign y_step    = ydown_ff ? (y_ff - COORD_BITS'(1)) : (y_ff + COORD_BITS'(1));

   // Sequence segments: load, then one pixel per free output slot
   always_comb begin
      state_in        = state_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      d_in            = d_ff;
      left_in         = left_ff;
      xmajor_in       = xmajor_ff;
      ydown_in        = ydown_ff;
      inc_diag_in     = inc_diag_ff;
      inc_straight_in = inc_straight_ff;
      pop             = 1'b0;
      emit            = 1'b0;
      case (state_ff)
         WALK_IDLE: begin
            if (seg_valid) begin
               pop             = 1'b1;
               x_in            = seg.sx;
               y_in            = seg.sy;
               d_in            = seg.d_init;
               left_in         = seg.span;
               xmajor_in       = seg.xmajor;
               ydown_in        = seg.ydown;
               inc_diag_in     = seg.inc_diag;
               inc_straight_in = seg.inc_straight;
               state_in        = WALK_RUN;
            end
         end
         WALK_RUN: begin
            if (out_free) begin
               emit = 1'b1;
               if (last_now) begin
                  state_in = WALK_IDLE;
               end else begin
                  left_in = left_ff - COORD_BITS'(1);
                  // Minor axis steps on the diagonal move
                  if (take_diag) begin
                     d_in = d_ff + $signed({2'b00, inc_diag_ff});
                     if (xmajor_ff) begin
                        y_in = y_step;
                     end else begin
                        x_in = x_ff + COORD_BITS'(1);
                     end
                  end else begin
                     d_in = d_ff - $signed({2'b00, inc_straight_ff});
                  end
                  // Major axis steps every pixel
                  if (xmajor_ff) begin
                     x_in = x_ff + COORD_BITS'(1);
                  end else begin
                     y_in = y_step;
                  end
               end
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

   // Load the output register on emit, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         pix_x_in     = x_ff;
         pix_y_in     = y_ff;
         last_in      = last_now;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WALK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      y_ff            <= y_in;
      d_ff            <= d_in;
      left_ff         <= left_in;
      xmajor_ff       <= xmajor_in;
      ydown_ff        <= ydown_in;
      inc_diag_ff     <= inc_diag_in;
      inc_straight_ff <= inc_straight_in;
      pix_x_ff        <= pix_x_in;
      pix_y_ff        <= pix_y_in;
      last_ff         <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = pix_x_ff;
   assign rsp_pixel_y    = pix_y_ff;
   assign rsp_last_pixel = last_ff;

   // Remaining count falls by one per non-final pixel
   `MLR_ASSERT_NEXT(a_left_dec, emit && !last_now, left_ff == $past(left_ff) - COORD_BITS'(1))
   // Final pixel returns the walker to idle with the beat presented
   `MLR_ASSERT_NEXT(a_last_idle, emit && last_now, state_ff == WALK_IDLE && rsp_last_pixel)
   // A new segment is only taken while no walk is in progress
   `MLR_ASSERT_IMPL(a_pop_idle, pop, state_ff == WALK_IDLE && !emit)

endmodule

/* src/midpoint_line_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// Turns a segment between two grid points into a run of pixel beats, the
// final one flagged, using the integer midpoint decision variable.
// ----------------------------------------------------------------------------
// Each request beat is one segment; it produces span + 1 response beats, where
// span is the larger of |dx| and |dy|, starting at the endpoint with the smaller
// x. The setup stage takes a segment every cycle while its two-entry queue has
// room. The walker emits one pixel per cycle while the response side accepts
// them, and loads each segment from the queue in its idle state before walking
// it; it takes no new segment until it has emitted the current one's last pixel.
module midpoint_line_rasterizer import mlr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_last_pixel
);

   logic    push, push_ready;
   seg_type push_seg;
   logic    pop, pop_valid;
   seg_type pop_seg;

   // Classify the incoming segment
   mlr_setup u_setup (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .push        (push),
      .push_ready  (push_ready),
      .seg         (push_seg)
   );

   // Hold segments between setup and walker
   mlr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_seg   (push_seg),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_seg    (pop_seg)
   );

   // Walk the segment and present pixels
   mlr_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .seg_valid      (pop_valid),
      .seg            (pop_seg),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

/* tb/sv/midpoint_line_rasterizer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint line rasterizer testbench
// Sends line segments through the request channel and predicts the pixel run
// of each one with a midpoint walk of its own. Every response beat is checked
// in order against that prediction. Both channels idle and stall at random,
// with one long response hold-off and pauses that let the block drain.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_tb;
   import mlr_pkg::*;

   typedef logic [COORD_BITS-1:0] coord_type;

   // One predicted response beat
   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_beat_type;

   localparam int GRID_MAX     = (1 << COORD_BITS) - 1;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 300;

   logic      clock       = 1'b0;
   logic      reset       = 1'b1;
   logic      req_valid   = 1'b0;
   coord_type req_x_start = '0;
   coord_type req_y_start = '0;
   coord_type req_x_end   = '0;
   coord_type req_y_end   = '0;
   logic      rsp_ready   = 1'b0;
   logic      req_ready;
   logic      rsp_valid;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   logic      rsp_last_pixel;

   pixel_beat_type pending_pixels[$];
   int             mismatch_count   = 0;
   bit             sender_gaps_on   = 1'b1;
   bit             receiver_stall_on = 1'b1;
   int             hold_off_request = 0;

   midpoint_line_rasterizer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length: mostly short, sometimes medium, rarely long
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return $urandom_range(1, 3);
      end else if (pick < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(16, 40);
   endfunction

   // Walk one segment with the midpoint decision variable and queue its pixels
   function automatic void rasterize_segment(input coord_type xa, input coord_type ya,
                                             input coord_type xb, input coord_type yb);
      bit             swapped;
      bit             ydown;
      bit             xmajor;
      int             sx, sy, fx, fy;
      int             adx, ady, ystep;
      int             span, minor, d, inc_diag, inc_straight;
      int             x, y;
      pixel_beat_type beat;
      swapped = xb < xa;
      sx = swapped ? xb : xa;
      sy = swapped ? yb : ya;
      fx = swapped ? xa : xb;
      fy = swapped ? ya : yb;
      adx   = fx - sx;
      ydown = fy < sy;
      ady   = ydown ? (sy - fy) : (fy - sy);
      ystep = ydown ? -1 : 1;
      // Ties go to x only when walking up and to the right unswapped
      if (!swapped && yb >= ya) begin
         xmajor = ady <= adx;
      end else begin
         xmajor = adx > ady;
      end
      span         = xmajor ? adx : ady;
      minor        = xmajor ? ady : adx;
      d            = span - 2 * minor;
      inc_diag     = 2 * (span - minor);
      inc_straight = -2 * minor;
      x = sx;
      y = sy;
      for (int n = 0; n <= span; n++) begin
         beat.x    = coord_type'(x);
         beat.y    = coord_type'(y);
         beat.last = (n == span);
         pending_pixels.push_back(beat);
         // Step the minor axis on a non-positive decision value
         if (d <= 0) begin
            d += inc_diag;
            if (xmajor) begin
               y += ystep;
            end else begin
               x += 1;
            end
         end else begin
            d += inc_straight;
         end
         if (xmajor) begin
            x += 1;
         end else begin
            y += ystep;
         end
      end
   endfunction

   // Offer one segment and hold it until accepted; returns at the accepting edge
   task automatic send_segment(input coord_type xa, input coord_type ya,
                               input coord_type xb, input coord_type yb);
      int gap;
      gap = (sender_gaps_on && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_start <= xa;
      req_y_start <= ya;
      req_x_end   <= xb;
      req_y_end   <= yb;
      // Inputs only move at rising edges, so ready is settled at the falling edge
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      rasterize_segment(xa, ya, xb, yb);
      @(posedge clock);
   endtask

   // Drop valid and wait until every predicted pixel has arrived
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Random segment: short lines near the start point, or anywhere on the grid, some flat, vertical or diagonal
   task automatic send_random_segment(input bit short_line);
      coord_type xa, ya, xb, yb;
      int        shape;
      int        run_len;
      xa = coord_type'($urandom_range(0, GRID_MAX));
      ya = coord_type'($urandom_range(0, GRID_MAX));
      xb = coord_type'($urandom_range(0, GRID_MAX));
      yb = coord_type'($urandom_range(0, GRID_MAX));
      shape = $urandom_range(0, 9);
      if (short_line) begin
         xb = coord_type'($urandom_range(int'(xa) > 4 ? int'(xa) - 4 : 0,
                          int'(xa) < GRID_MAX - 4 ? int'(xa) + 4 : GRID_MAX));
         yb = coord_type'($urandom_range(int'(ya) > 4 ? int'(ya) - 4 : 0,
                          int'(ya) < GRID_MAX - 4 ? int'(ya) + 4 : GRID_MAX));
      end else if (shape == 0) begin
         yb = ya;
      end else if (shape == 1) begin
         xb = xa;
      end else if (shape == 2) begin
         // Exact diagonal, up or down where it fits on the grid
         run_len = (xb > xa) ? int'(xb) - int'(xa) : int'(xa) - int'(xb);
         if ($urandom_range(0, 1) == 0 && int'(ya) + run_len <= GRID_MAX) begin
            yb = coord_type'(int'(ya) + run_len);
         end else if (int'(ya) >= run_len) begin
            yb = coord_type'(int'(ya) - run_len);
         end else begin
            yb = coord_type'(int'(ya) + run_len);
         end
      end
      send_segment(xa, ya, xb, yb);
   endtask

   // Extremes, axis-aligned lines, diagonals and every octant with and without swap
   task automatic test_directed_segments();
      int unsigned segs [23][4] = '{
         '{ 0,  0,  0,  0}, '{63, 63, 63, 63}, '{21, 42, 21, 42},
         '{ 0,  5, 63,  5}, '{63, 58,  0, 58}, '{ 7,  0,  7, 63},
         '{56, 63, 56,  0}, '{ 0,  0, 63, 63}, '{63, 63,  0,  0},
         '{ 0, 63, 63,  0}, '{63,  0,  0, 63}, '{ 0,  0, 63, 20},
         '{ 0,  0, 20, 63}, '{ 0, 63, 63, 43}, '{10, 60, 30,  1},
         '{63, 20,  0,  0}, '{20, 63,  0,  0}, '{50, 30, 10, 40},
         '{40, 10, 30, 50}, '{ 0,  0,  1,  0}, '{ 1,  1,  0,  0},
         '{ 5,  5,  6,  7}, '{42, 21, 21, 42}
      };
      foreach (segs[i]) begin
         send_segment(coord_type'(segs[i][0]), coord_type'(segs[i][1]),
                      coord_type'(segs[i][2]), coord_type'(segs[i][3]));
      end
   endtask

   // Random segments, with or without idling on either channel
   task automatic test_random_segments(input int count, input bit idling);
      sender_gaps_on    = idling;
      receiver_stall_on = idling;
      repeat (count) send_random_segment($urandom_range(0, 4) < 2);
      sender_gaps_on    = 1'b1;
      receiver_stall_on = 1'b1;
   endtask

   // Hold the response side off while requests keep coming, so input stalls
   task automatic test_back_pressure();
      wait_for_drain();
      hold_off_request = HOLD_CYCLES;
      repeat (12) send_random_segment($urandom_range(0, 1) == 1);
      wait_for_drain();
   endtask

   // Small bursts, each followed by a full drain and a pause
   task automatic test_sender_pause();
      repeat (5) begin
         repeat (3) send_random_segment($urandom_range(0, 1) == 1);
         wait_for_drain();
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   // Response side: random stalls, plus a long hold-off when asked
   initial begin : response_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (receiver_stall_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = gap_length() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each accepted pixel beat with the oldest prediction
   initial begin : pixel_checker
      pixel_beat_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected pixel beat, expected none, got (%0d, %0d, last %0b)",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_last_pixel);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_x !== want.x) begin
                  mismatch_count++;
                  $display("%0t: pixel_x mismatch, expected %0d, got %0d",
                           $time, want.x, rsp_pixel_x);
               end
               if (rsp_pixel_y !== want.y) begin
                  mismatch_count++;
                  $display("%0t: pixel_y mismatch, expected %0d, got %0d",
                           $time, want.y, rsp_pixel_y);
               end
               if (rsp_last_pixel !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last_pixel mismatch, expected %0b, got %0b",
                           $time, want.last, rsp_last_pixel);
               end
            end
         end
      end
   end

   // Test sequence
   initial begin : test_sequence
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_segments();
      test_random_segments(90, 1'b1);
      test_random_segments(30, 1'b0);
      test_back_pressure();
      test_sender_pause();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
